[rtl/core/bbc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Block buffer cache package
// Shared constants, command and status codes, and the control group that
// drives the recency list.
// ----------------------------------------------------------------------------
package bbc_pkg;

   localparam int SLOT_COUNT_DEFAULT = 16;
   localparam int SLOT_COUNT_MAX     = 256;
   localparam int IDX_W              = $clog2(SLOT_COUNT_MAX);

   localparam int CMD_W    = 2;
   localparam int BLOCK_W  = 32;
   localparam int SLOT_IO_W = 4;
   localparam int STATUS_W = 3;

   localparam logic [BLOCK_W-1:0] EMPTY_TAG = '1;

   localparam logic [CMD_W-1:0] CMD_GET     = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_DONE    = 2'd3;

   localparam logic [STATUS_W-1:0] ST_HIT     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ALLOC   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BUSY    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOFREE  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOTHELD = 3'd4;

   typedef struct packed {
      logic             rotate;
      logic             promote;
      logic [IDX_W-1:0] pos;
      logic [IDX_W-1:0] slot;
   } order_ctl_type;

endpackage

`default_nettype wire

[rtl/core/bbc_order.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Block buffer cache recency list
// Holds the slots in most-recently-used order. The list rotates by one entry
// per cycle during a scan, so the entry at the head is the one examined, and
// moves one slot to the front once its position is known.
// ----------------------------------------------------------------------------
module bbc_order
   import bbc_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT,
   localparam int SLOT_W    = $clog2(SLOT_COUNT)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire order_ctl_type     ctl,
   output logic [SLOT_W-1:0]      head
);

   logic [SLOT_W-1:0] order_ff [SLOT_COUNT];
   logic [SLOT_W-1:0] order_in [SLOT_COUNT];
   logic [SLOT_W-1:0] pos;

   assign pos  = ctl.pos[SLOT_W-1:0];
   assign head = order_ff[0];

   always_comb begin
      for (int k = 0; k < SLOT_COUNT; k++) begin
         order_in[k] = order_ff[k];
      end
      if (ctl.rotate) begin
         for (int k = 0; k < SLOT_COUNT - 1; k++) begin
            order_in[k] = order_ff[k+1];
         end
         order_in[SLOT_COUNT-1] = order_ff[0];
      end else if (ctl.promote) begin
         order_in[0] = ctl.slot[SLOT_W-1:0];
         for (int k = 1; k < SLOT_COUNT; k++) begin
            if (k <= int'(pos)) begin
               order_in[k] = order_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SLOT_COUNT; k++) begin
            order_ff[k] <= SLOT_W'(SLOT_COUNT - 1 - k);
         end
      end else begin
         for (int k = 0; k < SLOT_COUNT; k++) begin
            order_ff[k] <= order_in[k];
         end
      end
   end

endmodule

`default_nettype wire

[rtl/core/block_buffer_cache_lru.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// LRU block buffer cache controller
// Tracks SLOT_COUNT buffer slots with tags and busy, dirty and valid flags,
// kept in most-recently-used order. Serves get, write, release and
// disk-done commands and answers each with one result beat.
//
//   Channel  Direction  Handshake            Payload
//   req_     in         req_valid/req_stall  cmd, block_number, slot_in
//   rsp_     out        rsp_valid/rsp_stall  slot_out, status, fill/flush
//
// A get, or a release of a held slot, walks the recency list one entry a cycle
// through one shared comparator, and a release then moves its slot to the front;
// the other commands and rejected requests go from decode straight to the reply.
// The block takes one command at a time; req_stall is high until its result
// has been loaded into the output register. A stalled result holds there.
// Reset is synchronous.
// ----------------------------------------------------------------------------
module block_buffer_cache_lru
   import bbc_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [CMD_W-1:0]     req_cmd,
   input  wire logic [BLOCK_W-1:0]   req_block_number,
   input  wire logic [SLOT_IO_W-1:0] req_slot_in,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [SLOT_IO_W-1:0]      rsp_slot_out,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic                      rsp_fill_needed,
   output logic                      rsp_flush_needed
);

   localparam int SLOT_W = $clog2(SLOT_COUNT);
   localparam int CNT_W  = $clog2(SLOT_COUNT + 1);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_DECODE  = 3'd1;
   localparam logic [2:0] S_SCAN    = 3'd2;
   localparam logic [2:0] S_PROMOTE = 3'd3;
   localparam logic [2:0] S_REPLY   = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [CMD_W-1:0]       cmd_ff, cmd_in;
   logic [BLOCK_W-1:0]     blk_ff, blk_in;
   logic [SLOT_IO_W-1:0]   sel_ff, sel_in;

   logic [SLOT_COUNT-1:0]  busy_ff, busy_in;
   logic [SLOT_COUNT-1:0]  dirty_ff, dirty_in;
   logic [SLOT_COUNT-1:0]  valid_ff, valid_in;
   logic [SLOT_COUNT-1:0]  tag_set_ff, tag_set_in;

   logic [CNT_W-1:0]       scan_cnt_ff, scan_cnt_in;
   logic                   pipe_valid_ff, pipe_valid_in;
   logic [SLOT_W-1:0]      pipe_slot_ff, pipe_slot_in;
   logic [SLOT_W-1:0]      pipe_pos_ff, pipe_pos_in;
   logic                   hit_found_ff, hit_found_in;
   logic [SLOT_W-1:0]      hit_slot_ff, hit_slot_in;
   logic                   vic_found_ff, vic_found_in;
   logic [SLOT_W-1:0]      vic_slot_ff, vic_slot_in;
   logic [SLOT_W-1:0]      pos_ff, pos_in;

   logic [SLOT_IO_W-1:0]   res_slot_ff, res_slot_in;
   logic [STATUS_W-1:0]    res_status_ff, res_status_in;
   logic                   res_fill_ff, res_fill_in;
   logic                   res_flush_ff, res_flush_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SLOT_IO_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic                   rsp_fill_ff, rsp_fill_in;
   logic                   rsp_flush_ff, rsp_flush_in;

   logic [BLOCK_W-1:0]     tag_mem [SLOT_COUNT];
   logic [BLOCK_W-1:0]     tag_rd_ff;
   logic                   tag_we;

   logic [SLOT_W-1:0]      head;
   logic [SLOT_W-1:0]      sel_idx;
   logic                   sel_in_range;
   logic                   scan_done;
   logic [BLOCK_W-1:0]     cmp_a, cmp_b;
   logic                   cmp_eq;
   order_ctl_type          order_ctl;

   bbc_order #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_order (
      .clock (clock),
      .reset (reset),
      .ctl   (order_ctl),
      .head  (head)
   );

   assign sel_idx      = SLOT_W'(sel_ff);
   assign sel_in_range = 32'(sel_ff) < 32'(SLOT_COUNT);
   assign scan_done    = scan_cnt_ff == CNT_W'(SLOT_COUNT);

   // The one comparator: tags during a get, slot numbers during a release.
   assign cmp_a  = (cmd_ff == CMD_GET) ? tag_rd_ff : BLOCK_W'(pipe_slot_ff);
   assign cmp_b  = (cmd_ff == CMD_GET) ? blk_ff    : BLOCK_W'(sel_idx);
   assign cmp_eq = cmp_a == cmp_b;

   assign req_stall        = state_ff != S_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_slot_out     = rsp_slot_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_fill_needed  = rsp_fill_ff;
   assign rsp_flush_needed = rsp_flush_ff;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      blk_in        = blk_ff;
      sel_in        = sel_ff;
      busy_in       = busy_ff;
      dirty_in      = dirty_ff;
      valid_in      = valid_ff;
      tag_set_in    = tag_set_ff;
      scan_cnt_in   = scan_cnt_ff;
      pipe_valid_in = 1'b0;
      pipe_slot_in  = pipe_slot_ff;
      pipe_pos_in   = pipe_pos_ff;
      hit_found_in  = hit_found_ff;
      hit_slot_in   = hit_slot_ff;
      vic_found_in  = vic_found_ff;
      vic_slot_in   = vic_slot_ff;
      pos_in        = pos_ff;
      res_slot_in   = res_slot_ff;
      res_status_in = res_status_ff;
      res_fill_in   = res_fill_ff;
      res_flush_in  = res_flush_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;
      rsp_fill_in   = rsp_fill_ff;
      rsp_flush_in  = rsp_flush_ff;
      order_ctl     = '0;
      tag_we        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_cmd;
               blk_in   = req_block_number;
               sel_in   = req_slot_in;
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            scan_cnt_in   = '0;
            hit_found_in  = 1'b0;
            vic_found_in  = 1'b0;
            res_fill_in   = 1'b0;
            res_flush_in  = 1'b0;
            res_slot_in   = sel_ff;
            res_status_in = ST_HIT;
            state_in      = S_REPLY;
            if (cmd_ff == CMD_GET) begin
               if (blk_ff == EMPTY_TAG) begin
                  res_slot_in   = '0;
                  res_status_in = ST_NOFREE;
               end else begin
                  state_in = S_SCAN;
               end
            end else if (!sel_in_range) begin
               res_status_in = ST_NOTHELD;
            end else begin
               case (cmd_ff)
                  CMD_WRITE: begin
                     if (busy_ff[sel_idx]) begin
                        dirty_in[sel_idx] = 1'b1;
                        res_flush_in      = 1'b1;
                     end else begin
                        res_status_in = ST_NOTHELD;
                     end
                  end
                  CMD_RELEASE: begin
                     if (busy_ff[sel_idx]) begin
                        state_in = S_SCAN;
                     end else begin
                        res_status_in = ST_NOTHELD;
                     end
                  end
                  default: begin
                     valid_in[sel_idx] = 1'b1;
                     dirty_in[sel_idx] = 1'b0;
                  end
               endcase
            end
         end

         S_SCAN: begin
            if (!scan_done) begin
               order_ctl.rotate = 1'b1;
               scan_cnt_in      = scan_cnt_ff + CNT_W'(1);
               pipe_valid_in    = 1'b1;
               pipe_slot_in     = head;
               pipe_pos_in      = SLOT_W'(scan_cnt_ff);
            end
            if (pipe_valid_ff) begin
               if (cmd_ff == CMD_GET) begin
                  if (cmp_eq && tag_set_ff[pipe_slot_ff] && !hit_found_ff) begin
                     hit_found_in = 1'b1;
                     hit_slot_in  = pipe_slot_ff;
                  end
                  if (!busy_ff[pipe_slot_ff] && !dirty_ff[pipe_slot_ff]) begin
                     vic_found_in = 1'b1;
                     vic_slot_in  = pipe_slot_ff;
                  end
               end else if (cmp_eq) begin
                  pos_in = pipe_pos_ff;
               end
            end
            if (scan_done && !pipe_valid_ff) begin
               if (cmd_ff == CMD_RELEASE) begin
                  state_in = S_PROMOTE;
               end else begin
                  state_in = S_REPLY;
                  if (hit_found_ff) begin
                     res_slot_in = SLOT_IO_W'(hit_slot_ff);
                     if (busy_ff[hit_slot_ff]) begin
                        res_status_in = ST_BUSY;
                     end else begin
                        busy_in[hit_slot_ff] = 1'b1;
                        res_status_in        = ST_HIT;
                        res_fill_in          = !valid_ff[hit_slot_ff];
                     end
                  end else if (vic_found_ff) begin
                     tag_we                  = 1'b1;
                     tag_set_in[vic_slot_ff] = 1'b1;
                     busy_in[vic_slot_ff]    = 1'b1;
                     valid_in[vic_slot_ff]   = 1'b0;
                     dirty_in[vic_slot_ff]   = 1'b0;
                     res_slot_in             = SLOT_IO_W'(vic_slot_ff);
                     res_status_in           = ST_ALLOC;
                     res_fill_in             = 1'b1;
                  end else begin
                     res_slot_in   = '0;
                     res_status_in = ST_NOFREE;
                  end
               end
            end
         end

         S_PROMOTE: begin
            order_ctl.promote = 1'b1;
            order_ctl.pos     = IDX_W'(pos_ff);
            order_ctl.slot    = IDX_W'(sel_idx);
            busy_in[sel_idx]  = 1'b0;
            state_in          = S_REPLY;
         end

         S_REPLY: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_valid_in  = 1'b1;
               rsp_slot_in   = res_slot_ff;
               rsp_status_in = res_status_ff;
               rsp_fill_in   = res_fill_ff;
               rsp_flush_in  = res_flush_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem[vic_slot_ff] <= blk_ff;
      end
      tag_rd_ff <= tag_mem[head];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         busy_ff       <= '0;
         dirty_ff      <= '0;
         valid_ff      <= '0;
         tag_set_ff    <= '0;
         pipe_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         busy_ff       <= busy_in;
         dirty_ff      <= dirty_in;
         valid_ff      <= valid_in;
         tag_set_ff    <= tag_set_in;
         pipe_valid_ff <= pipe_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      blk_ff        <= blk_in;
      sel_ff        <= sel_in;
      scan_cnt_ff   <= scan_cnt_in;
      pipe_slot_ff  <= pipe_slot_in;
      pipe_pos_ff   <= pipe_pos_in;
      hit_found_ff  <= hit_found_in;
      hit_slot_ff   <= hit_slot_in;
      vic_found_ff  <= vic_found_in;
      vic_slot_ff   <= vic_slot_in;
      pos_ff        <= pos_in;
      res_slot_ff   <= res_slot_in;
      res_status_ff <= res_status_in;
      res_fill_ff   <= res_fill_in;
      res_flush_ff  <= res_flush_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fill_ff   <= rsp_fill_in;
      rsp_flush_ff  <= rsp_flush_in;
   end

endmodule

`default_nettype wire

[rtl/core/bbc_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Block buffer cache port checker
// Watches the result channel of the cache controller for status and flag
// combinations that the controller must never produce.
// ----------------------------------------------------------------------------
module bbc_checker
   import bbc_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_stall,
   input wire logic [SLOT_IO_W-1:0] rsp_slot_out,
   input wire logic [STATUS_W-1:0]  rsp_status,
   input wire logic                 rsp_fill_needed,
   input wire logic                 rsp_flush_needed
);

   // A fill is only asked for on a granted slot.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fill_needed |-> rsp_status == ST_HIT || rsp_status == ST_ALLOC)
      else $error("fill requested on a beat that grants no slot");

   // A flush comes only with a successful write, never together with a fill.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_flush_needed |-> rsp_status == ST_HIT && !rsp_fill_needed)
      else $error("flush requested on a beat that is not a successful write");

   // A freshly claimed slot always needs its data read from disk.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_ALLOC |-> rsp_fill_needed && !rsp_flush_needed)
      else $error("allocation beat without a fill request");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_NOFREE |-> rsp_slot_out == '0)
      else $error("no-free-slot beat carries a slot number");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_slot_out) && $stable(rsp_status))
      else $error("stalled result beat changed or dropped");

endmodule

bind block_buffer_cache_lru bbc_checker u_bbc_checker (.*);

`default_nettype wire
